FILE: hdl/mwf_pkg.sv
// Shared types and constants of the median window filter.
`timescale 1ns / 1ps
package mwf_pkg;

   localparam int PIX_W    = 8;
   localparam int ROW_W    = 12;
   localparam int COL_W    = 12;
   localparam int SLOT_W   = 3;
   localparam int CSR_AW   = 1;
   localparam int CSR_DW   = 13;
   localparam int ROWS_MAX = 4096;
   localparam int Q_DEPTH  = 4;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   localparam logic [CSR_AW-1:0] REG_WIDTH  = 1'b0;
   localparam logic [CSR_AW-1:0] REG_HEIGHT = 1'b1;

   // one output position to compute
   typedef struct packed {
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [SLOT_W-1:0] slot;
      logic              last;
   } mwf_job_type;

   // line store write
   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] slot;
      logic [COL_W-1:0]  col;
      logic [PIX_W-1:0]  data;
   } mwf_wr_type;

   // jobs whose line store reads are still outstanding
   typedef struct packed {
      logic             pending;
      logic [ROW_W-1:0] oldest_row;
   } mwf_stat_type;

endpackage

FILE: hdl/mwf_front.sv
// Front end: config registers, position counters, line store writes, job issue.
`timescale 1ns / 1ps
module mwf_front #(
   parameter int KERNEL_SIZE = 5,
   parameter int MAX_WIDTH   = 1024,
   localparam int CW = $clog2(MAX_WIDTH),
   localparam int SW = $clog2(KERNEL_SIZE + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic                          req_op,
   input  logic [mwf_pkg::PIX_W-1:0]     req_pixel,
   input  logic                          csr_we,
   input  logic [mwf_pkg::CSR_AW-1:0]    csr_addr,
   input  logic [mwf_pkg::CSR_DW-1:0]    csr_wdata,
   input  logic                          q_full,
   input  mwf_pkg::mwf_stat_type         stat,
   output logic                          job_push,
   output mwf_pkg::mwf_job_type          job,
   output mwf_pkg::mwf_wr_type           wr,
   output logic [CW-1:0]                 wm1,
   output logic [mwf_pkg::ROW_W-1:0]     hm1
);
   import mwf_pkg::*;

   localparam int HALF_K = KERNEL_SIZE / 2;
   localparam int RING   = KERNEL_SIZE + 1;

   logic [10:0]      width_ff, width_in;
   logic [12:0]      height_ff, height_in;
   logic [12:0]      in_row_ff, in_row_in;
   logic [CW-1:0]    in_col_ff, in_col_in;
   logic [SW-1:0]    in_slot_ff, in_slot_in;
   logic [ROW_W-1:0] out_row_ff, out_row_in;
   logic [CW-1:0]    out_col_ff, out_col_in;
   logic [SW-1:0]    out_slot_ff, out_slot_in;
   logic             gap_ff, gap_in;

   logic          accept, do_wr, ready, emit, last, hazard_ok;
   logic [12:0]   orow_p, nr;
   logic [CW:0]   ocol_p, nc;

   always_comb begin
      if (width_ff == '0) wm1 = '0;
      else if ({2'b00, width_ff} > 13'(MAX_WIDTH)) wm1 = CW'(MAX_WIDTH - 1);
      else wm1 = CW'(width_ff - 11'd1);
      if (height_ff == '0) hm1 = '0;
      else if (height_ff > 13'(ROWS_MAX)) hm1 = ROW_W'(ROWS_MAX - 1);
      else hm1 = ROW_W'(height_ff - 13'd1);
   end

   // a write to row R reuses the slot of row R-RING; keep it clear of pending reads
   assign hazard_ok  = !stat.pending ||
                       (in_row_ff <= ({1'b0, stat.oldest_row} + 13'(HALF_K + 1)));
   assign req_tready = !q_full && !gap_ff && hazard_ok;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      in_row_in   = in_row_ff;
      in_col_in   = in_col_ff;
      in_slot_in  = in_slot_ff;
      out_row_in  = out_row_ff;
      out_col_in  = out_col_ff;
      out_slot_in = out_slot_ff;
      width_in    = width_ff;
      height_in   = height_ff;

      do_wr = accept && (req_op == OP_PIXEL) && (in_row_ff <= {1'b0, hm1});
      if (do_wr) begin
         if (in_col_ff == wm1) begin
            in_col_in  = '0;
            in_row_in  = in_row_ff + 13'd1;
            in_slot_in = (in_slot_ff == SW'(RING - 1)) ? '0 : in_slot_ff + SW'(1);
         end else begin
            in_col_in = in_col_ff + CW'(1);
         end
      end

      orow_p = {1'b0, out_row_ff} + 13'(HALF_K);
      nr     = (orow_p > {1'b0, hm1}) ? {1'b0, hm1} : orow_p;
      ocol_p = {1'b0, out_col_ff} + (CW+1)'(HALF_K);
      nc     = (ocol_p > {1'b0, wm1}) ? {1'b0, wm1} : ocol_p;
      ready  = (in_row_in > nr) || ((in_row_in == nr) && ({1'b0, in_col_in} > nc));
      emit   = accept && ready;
      last   = (out_row_ff == hm1) && (out_col_ff == wm1);

      if (emit) begin
         if (out_col_ff == wm1) begin
            out_col_in  = '0;
            out_row_in  = out_row_ff + ROW_W'(1);
            out_slot_in = (out_slot_ff == SW'(RING - 1)) ? '0 : out_slot_ff + SW'(1);
         end else begin
            out_col_in = out_col_ff + CW'(1);
         end
      end

      // hold off the next frame until the old one has read all it needs
      if (emit && last) gap_in = 1'b1;
      else if (!stat.pending) gap_in = 1'b0;
      else gap_in = gap_ff;

      if (csr_we) begin
         unique case (csr_addr)
            REG_WIDTH:  width_in  = csr_wdata[10:0];
            REG_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end

      if (csr_we || (emit && last)) begin
         in_row_in   = '0;
         in_col_in   = '0;
         in_slot_in  = '0;
         out_row_in  = '0;
         out_col_in  = '0;
         out_slot_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= 11'd512;
         height_ff   <= 13'd512;
         in_row_ff   <= '0;
         in_col_ff   <= '0;
         in_slot_ff  <= '0;
         out_row_ff  <= '0;
         out_col_ff  <= '0;
         out_slot_ff <= '0;
         gap_ff      <= 1'b0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         in_row_ff   <= in_row_in;
         in_col_ff   <= in_col_in;
         in_slot_ff  <= in_slot_in;
         out_row_ff  <= out_row_in;
         out_col_ff  <= out_col_in;
         out_slot_ff <= out_slot_in;
         gap_ff      <= gap_in;
      end
   end

   assign job_push = emit;
   assign job.row  = out_row_ff;
   assign job.col  = COL_W'(out_col_ff);
   assign job.slot = SLOT_W'(out_slot_ff);
   assign job.last = last;

   assign wr.en   = do_wr;
   assign wr.slot = SLOT_W'(in_slot_ff);
   assign wr.col  = COL_W'(in_col_ff);
   assign wr.data = req_pixel;

endmodule

FILE: hdl/mwf_queue.sv
// Short job queue between front end and window builder.
`timescale 1ns / 1ps
module mwf_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  mwf_pkg::mwf_job_type din,
   input  logic                 pop,
   output mwf_pkg::mwf_job_type dout,
   output logic                 full,
   output logic                 empty
);
   import mwf_pkg::*;

   localparam int QAW = $clog2(Q_DEPTH);

   mwf_job_type    mem_ff [Q_DEPTH];
   logic [QAW-1:0] wp_ff, rp_ff;
   logic [QAW:0]   cnt_ff;

   assign full  = (cnt_ff == (QAW+1)'(Q_DEPTH));
   assign empty = (cnt_ff == '0);
   assign dout  = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= din;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + QAW'(1);
         if (pop) rp_ff <= rp_ff + QAW'(1);
         if (push && !pop) cnt_ff <= cnt_ff + (QAW+1)'(1);
         else if (pop && !push) cnt_ff <= cnt_ff - (QAW+1)'(1);
      end
   end

endmodule

FILE: hdl/mwf_window.sv
// Back end part one: line store banks, column reads and the sliding window.
`timescale 1ns / 1ps
module mwf_window #(
   parameter int KERNEL_SIZE = 5,
   parameter int MAX_WIDTH   = 1024,
   localparam int CW = $clog2(MAX_WIDTH),
   localparam int NE = KERNEL_SIZE * KERNEL_SIZE
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mwf_pkg::mwf_wr_type           wr,
   input  logic [CW-1:0]                 wm1,
   input  logic [mwf_pkg::ROW_W-1:0]     hm1,
   input  logic                          q_empty,
   input  mwf_pkg::mwf_job_type          q_head,
   output logic                          q_pop,
   output mwf_pkg::mwf_stat_type         stat,
   input  logic                          adv,
   output logic                          win_v,
   output logic [mwf_pkg::PIX_W-1:0]     win_pix [NE],
   output logic [NE-1:0]                 win_ok,
   output logic                          win_last
);
   import mwf_pkg::*;

   localparam int HALF_K = KERNEL_SIZE / 2;
   localparam int RING   = KERNEL_SIZE + 1;
   localparam int SW     = $clog2(RING);

   // column sequencer
   logic        active_ff;
   mwf_job_type job_ff;
   logic [CW:0] seq_col_ff;

   mwf_job_type cur;
   logic        have, first, is_end, issue, col_ok;
   logic [CW-1:0] cur_c;
   logic [CW:0] cend, cur_col;
   logic [KERNEL_SIZE-1:0] row_ok;
   logic [SW-1:0] row_slot [KERNEL_SIZE];

   // read stage
   logic [PIX_W-1:0] rd_ff [RING];
   logic             s1_v_ff, s1_first_ff, s1_end_ff, s1_colok_ff, s1_last_ff;
   logic [KERNEL_SIZE-1:0] s1_rowok_ff;
   logic [SW-1:0]    s1_slot_ff [KERNEL_SIZE];

   // window, indexed [column][row], newest column at the top index
   logic [PIX_W-1:0]       win_ff [KERNEL_SIZE][KERNEL_SIZE];
   logic [KERNEL_SIZE-1:0] wok_ff [KERNEL_SIZE];
   logic [PIX_W-1:0]       sh_pix [KERNEL_SIZE][KERNEL_SIZE];
   logic [KERNEL_SIZE-1:0] sh_ok  [KERNEL_SIZE];

   assign cur     = active_ff ? job_ff : q_head;
   assign have    = active_ff || !q_empty;
   assign cur_c   = cur.col[CW-1:0];
   assign cend    = {1'b0, cur_c} + (CW+1)'(HALF_K);
   assign cur_col = active_ff ? seq_col_ff : ((cur_c == '0) ? '0 : cend);
   // start of a row preloads the columns right of the first position
   assign first   = !active_ff && (cur_c == '0);
   assign is_end  = (cur_col == cend);
   assign issue   = have && adv;
   assign q_pop   = issue && !active_ff;
   assign col_ok  = (cur_col <= {1'b0, wm1});

   assign stat.pending    = have;
   assign stat.oldest_row = cur.row;

   always_comb begin
      int rr;
      int ss;
      for (int k = 0; k < KERNEL_SIZE; k++) begin
         rr = int'(cur.row) + k - HALF_K;
         row_ok[k] = (rr >= 0) && (rr <= int'(hm1));
         ss = int'(cur.slot) + k - HALF_K;
         if (ss < 0) ss = ss + RING;
         else if (ss >= RING) ss = ss - RING;
         row_slot[k] = SW'(ss);
      end
   end

   for (genvar b = 0; b < RING; b++) begin : g_bank
      logic [PIX_W-1:0] bank_mem [MAX_WIDTH];
      always_ff @(posedge clock) begin
         if (wr.en && (wr.slot == SLOT_W'(b))) bank_mem[wr.col[CW-1:0]] <= wr.data;
         if (adv) rd_ff[b] <= bank_mem[cur_col[CW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         s1_v_ff   <= 1'b0;
         win_v     <= 1'b0;
      end else if (adv) begin
         if (issue) active_ff <= !is_end;
         s1_v_ff <= issue;
         win_v   <= s1_v_ff && s1_end_ff;
      end
   end

   always_comb begin
      for (int c = 0; c < KERNEL_SIZE - 1; c++) begin
         sh_pix[c] = win_ff[c + 1];
         sh_ok[c]  = s1_first_ff ? '0 : wok_ff[c + 1];
      end
      for (int k = 0; k < KERNEL_SIZE; k++) begin
         sh_pix[KERNEL_SIZE-1][k] = rd_ff[s1_slot_ff[k]];
         sh_ok[KERNEL_SIZE-1][k]  = s1_colok_ff && s1_rowok_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (issue) begin
            job_ff     <= cur;
            seq_col_ff <= cur_col + (CW+1)'(1);
         end
         s1_first_ff <= first;
         s1_end_ff   <= is_end;
         s1_colok_ff <= col_ok;
         s1_rowok_ff <= row_ok;
         s1_slot_ff  <= row_slot;
         s1_last_ff  <= cur.last;
         if (s1_v_ff) begin
            win_ff <= sh_pix;
            wok_ff <= sh_ok;
         end
         if (s1_v_ff && s1_end_ff) begin
            for (int c = 0; c < KERNEL_SIZE; c++) begin
               for (int k = 0; k < KERNEL_SIZE; k++) begin
                  win_pix[c*KERNEL_SIZE + k] <= sh_pix[c][k];
                  win_ok[c*KERNEL_SIZE + k]  <= sh_ok[c][k];
               end
            end
            win_last <= s1_last_ff;
         end
      end
   end

endmodule

FILE: hdl/mwf_median.sv
// Back end part two: rank select over the window and the output register.
`timescale 1ns / 1ps
module mwf_median #(
   parameter int KERNEL_SIZE = 5,
   localparam int NE = KERNEL_SIZE * KERNEL_SIZE
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      win_v,
   input  logic [mwf_pkg::PIX_W-1:0] win_pix [NE],
   input  logic [NE-1:0]             win_ok,
   input  logic                      win_last,
   output logic                      adv,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [mwf_pkg::PIX_W-1:0] rsp_tdata,
   output logic                      rsp_tlast
);
   import mwf_pkg::*;

   localparam int NW = $clog2(NE + 1);

   logic [NE-1:0]    lt [NE];
   logic [NE-1:0]    lt_ff [NE];
   logic [PIX_W-1:0] pix3_ff [NE];
   logic [NE-1:0]    ok3_ff;
   logic             v3_ff, last3_ff;

   logic [NE-1:0]    sel, sel_ff;
   logic [NW-1:0]    cnt;
   logic [PIX_W-1:0] pix4_ff [NE];
   logic             v4_ff, last4_ff;
   logic [PIX_W-1:0] med;

   assign adv = !rsp_tvalid || rsp_tready;

   // lt[i][j]: element j ranks below element i (ties broken by position)
   always_comb begin
      for (int i = 0; i < NE; i++) begin
         for (int j = 0; j < NE; j++) begin
            lt[i][j] = win_ok[j] && ((win_pix[j] < win_pix[i]) ||
                                     ((win_pix[j] == win_pix[i]) && (j < i)));
         end
      end
   end

   always_comb begin
      cnt = NW'($countones(ok3_ff));
      for (int i = 0; i < NE; i++) begin
         sel[i] = ok3_ff[i] && (NW'($countones(lt_ff[i])) == (cnt >> 1));
      end
   end

   always_comb begin
      med = '0;
      for (int i = 0; i < NE; i++) begin
         if (sel_ff[i]) med = med | pix4_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff      <= 1'b0;
         v4_ff      <= 1'b0;
         rsp_tvalid <= 1'b0;
      end else if (adv) begin
         v3_ff      <= win_v;
         v4_ff      <= v3_ff;
         rsp_tvalid <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lt_ff     <= lt;
         pix3_ff   <= win_pix;
         ok3_ff    <= win_ok;
         last3_ff  <= win_last;
         sel_ff    <= sel;
         pix4_ff   <= pix3_ff;
         last4_ff  <= last3_ff;
         rsp_tdata <= med;
         rsp_tlast <= last4_ff;
      end
   end

endmodule

FILE: hdl/median_window_filter.sv
// Top level of the streaming median window filter.
//
//  port group | dir | payload                        | accepted when
//  req_*      | in  | tdata: pixel_in, tuser: op     | req_tvalid & req_tready
//  rsp_*      | out | tdata: pixel_out, tlast: end   | rsp_tvalid & rsp_tready
//  csr_*      | in  | index 0 width, 1 height        | csr_we
//
// One word per clock in steady state while no stall holds the flow. At the start
// of each output row the column reader first loads the leading columns,
// and a new frame waits until the last window reads of the old frame are done.
// A complete window passes the compare, select and output registers in turn.
// Reset is synchronous; the line store is not cleared and needs no sweep.
// Stalls on rsp_tready hold the whole back end; the job queue lets input run on.
`timescale 1ns / 1ps
module median_window_filter #(
   parameter int KERNEL_SIZE = 5,
   parameter int MAX_WIDTH   = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [7:0] pixel_in
   input  logic                          req_tuser,   // [0] operation
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata,   // [7:0] pixel_out
   output logic                          rsp_tlast,   // frame_end
   input  logic                          csr_we,
   input  logic [mwf_pkg::CSR_AW-1:0]    csr_addr,
   input  logic [mwf_pkg::CSR_DW-1:0]    csr_wdata
);
   import mwf_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int NE = KERNEL_SIZE * KERNEL_SIZE;

   logic             q_full, q_empty, job_push, q_pop, adv;
   mwf_job_type      job, q_head;
   mwf_wr_type       wr;
   mwf_stat_type     stat;
   logic [CW-1:0]    wm1;
   logic [ROW_W-1:0] hm1;
   logic             win_v, win_last;
   logic [PIX_W-1:0] win_pix [NE];
   logic [NE-1:0]    win_ok;

   mwf_front #(.KERNEL_SIZE(KERNEL_SIZE), .MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_op(req_tuser), .req_pixel(req_tdata),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .q_full(q_full), .stat(stat), .job_push(job_push), .job(job),
      .wr(wr), .wm1(wm1), .hm1(hm1)
   );

   mwf_queue u_queue (
      .clock(clock), .reset(reset),
      .push(job_push), .din(job), .pop(q_pop), .dout(q_head),
      .full(q_full), .empty(q_empty)
   );

   mwf_window #(.KERNEL_SIZE(KERNEL_SIZE), .MAX_WIDTH(MAX_WIDTH)) u_window (
      .clock(clock), .reset(reset), .wr(wr), .wm1(wm1), .hm1(hm1),
      .q_empty(q_empty), .q_head(q_head), .q_pop(q_pop), .stat(stat),
      .adv(adv), .win_v(win_v), .win_pix(win_pix), .win_ok(win_ok),
      .win_last(win_last)
   );

   mwf_median #(.KERNEL_SIZE(KERNEL_SIZE)) u_median (
      .clock(clock), .reset(reset),
      .win_v(win_v), .win_pix(win_pix), .win_ok(win_ok), .win_last(win_last),
      .adv(adv), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

`ifndef SYNTH
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      job_push |-> !q_full) else $error("job pushed into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty) else $error("job popped from empty queue");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("result word changed while waiting");
`endif

endmodule

FILE: tb/median_window_filter_test.sv
// Testbench for median_window_filter: predicted medians checked word by word.
`timescale 1ns / 1ps
module median_window_filter_test;
   import mwf_pkg::*;

   localparam int HALF_K   = 2;
   localparam int RING     = 6;
   localparam int MAX_COLS = 1024;

   typedef struct {
      logic       op;
      logic [7:0] pix;
   } pixel_word_type;

   typedef struct {
      logic [7:0] median;
      logic       frame_end;
   } median_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_we = 1'b0;
   logic [CSR_AW-1:0] csr_addr = '0;
   logic [CSR_DW-1:0] csr_wdata = '0;

   median_window_filter dut (.*);

   pixel_word_type  pixel_q[$];
   median_word_type median_q[$];
   int errors = 0;
   int send_gap = 0;
   int stall = 0;
   bit calm = 0;
   pixel_word_type next_word;

   // mirror of the block's state
   logic [7:0] line_mem[RING][MAX_COLS];
   int frame_w = 512, frame_h = 512;
   int in_row = 0, in_col = 0, out_row = 0, out_col = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   task automatic report(input string what);
      errors++;
      $display("ERROR at %0t: %s", $realtime, what);
   endtask

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   task automatic predict_median(input logic op, input logic [7:0] pix);
      int w, h, nr, nc, n, r, c, j;
      logic [7:0] win[25];
      logic [7:0] v;
      median_word_type m;
      w = (frame_w == 0) ? 1 : (frame_w > MAX_COLS ? MAX_COLS : frame_w);
      h = (frame_h == 0) ? 1 : (frame_h > ROWS_MAX ? ROWS_MAX : frame_h);
      if (op == OP_PIXEL && in_row < h) begin
         line_mem[in_row % RING][in_col] = pix;
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
         end
      end
      if (out_row >= h) return;
      nr = (out_row + HALF_K > h - 1) ? h - 1 : out_row + HALF_K;
      nc = (out_col + HALF_K > w - 1) ? w - 1 : out_col + HALF_K;
      if (!(in_row > nr || (in_row == nr && in_col > nc))) return;
      n = 0;
      for (r = out_row - HALF_K; r <= out_row + HALF_K; r++)
         for (c = out_col - HALF_K; c <= out_col + HALF_K; c++)
            if (r >= 0 && r < h && c >= 0 && c < w) begin
               win[n] = line_mem[r % RING][c];
               n++;
            end
      for (int i = 1; i < n; i++) begin
         v = win[i];
         j = i;
         while (j > 0 && win[j-1] > v) begin
            win[j] = win[j-1];
            j--;
         end
         win[j] = v;
      end
      m.median = win[n/2];
      m.frame_end = (out_row == h - 1) && (out_col == w - 1);
      median_q.insert(median_q.size(), m);
      if (m.frame_end) begin
         in_row = 0; in_col = 0; out_row = 0; out_col = 0;
      end else begin
         out_col++;
         if (out_col >= w) begin
            out_col = 0;
            out_row++;
         end
      end
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) predict_median(req_tuser, req_tdata);
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pixel_q.size() > 0) begin
               next_word = pixel_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= next_word.pix;
               req_tuser <= next_word.op;
               send_gap = pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (median_q.size() == 0) begin
               report($sformatf("unexpected word %0d last %0b", rsp_tdata, rsp_tlast));
            end else begin
               if (rsp_tdata !== median_q[0].median)
                  report($sformatf("median %0d, want %0d", rsp_tdata, median_q[0].median));
               if (rsp_tlast !== median_q[0].frame_end)
                  report($sformatf("frame_end %0b, want %0b", rsp_tlast,
                                   median_q[0].frame_end));
               void'(median_q.pop_front());
            end
         end
         if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            stall = pick_gap();
         end
      end
   end

   task automatic wait_idle();
      @(negedge clock);
      while (pixel_q.size() > 0 || req_tvalid || median_q.size() > 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_AW-1:0] idx, input logic [CSR_DW-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      if (idx == REG_WIDTH) frame_w = val & 13'h07FF;
      else frame_h = val;
      in_row = 0; in_col = 0; out_row = 0; out_col = 0;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_size(input logic [CSR_DW-1:0] w, input logic [CSR_DW-1:0] h);
      wait_idle();
      calm = ($urandom_range(4) == 0);
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
   endtask

   function automatic logic [7:0] pick_pixel(input int mode);
      case (mode)
         0: return 8'($urandom_range(255));
         1: return 8'($urandom_range(103, 100));
         default: return $urandom_range(1) ? 8'hFF : 8'h00;
      endcase
   endfunction

   // full frame, stray drains inside it, then tail words to flush the results
   task automatic add_frame(input int w, input int h, output int count);
      pixel_word_type pw;
      int mode;
      int tail;
      bit tail_pixels;
      mode = $urandom_range(2);
      tail_pixels = ($urandom_range(3) == 0);
      tail = ((h - 1 < HALF_K) ? h - 1 : HALF_K) * w + HALF_K + 1;
      count = 0;
      for (int i = 0; i < w * h; i++) begin
         if ($urandom_range(15) == 0) begin
            pw.op = OP_DRAIN;
            pw.pix = 8'($urandom_range(255));
            pixel_q.insert(pixel_q.size(), pw);
         end
         pw.op = OP_PIXEL;
         pw.pix = pick_pixel(mode);
         pixel_q.insert(pixel_q.size(), pw);
         count++;
      end
      for (int i = 0; i < tail; i++) begin
         pw.op = tail_pixels ? OP_PIXEL : OP_DRAIN;
         pw.pix = pick_pixel(mode);
         pixel_q.insert(pixel_q.size(), pw);
         count++;
      end
   endtask

   initial begin
      int n, total, w, h, cut;
      pixel_word_type pw;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: zero and oversize registers
      set_size(13'h0000, 13'h0000);
      add_frame(1, 1, n);
      set_size(13'h0003, 13'h0002);
      add_frame(3, 2, n);
      set_size(13'h1FFF, 13'h0001);
      add_frame(1024, 1, n);
      // oversize height: only the first rows are sent
      set_size(13'h0001, 13'h1FFF);
      for (int i = 0; i < 40; i++) begin
         pw.op = OP_PIXEL;
         pw.pix = 8'($urandom_range(255));
         pixel_q.insert(pixel_q.size(), pw);
      end
      set_size(13'h0005, 13'h0005);
      add_frame(5, 5, n);
      add_frame(5, 5, n);
      // sender holds until everything has come back
      wait_idle();
      add_frame(5, 5, n);

      total = 0;
      while (total < 900) begin
         w = ($urandom_range(9) == 0) ? $urandom_range(64, 17) : $urandom_range(16, 1);
         h = $urandom_range(12, 1);
         set_size(13'(w | ($urandom_range(3) << 11)), 13'(h));
         if ($urandom_range(7) == 0) begin
            // broken frame: cut short, then restarted by the next write
            cut = $urandom_range(w * h + w);
            for (int i = 0; i < cut; i++) begin
               pw.op = ($urandom_range(5) == 0) ? OP_DRAIN : OP_PIXEL;
               pw.pix = 8'($urandom_range(255));
               pixel_q.insert(pixel_q.size(), pw);
            end
            total += cut;
         end else begin
            repeat ($urandom_range(3, 1)) begin
               add_frame(w, h, n);
               total += n;
            end
         end
      end

      wait_idle();
      repeat (30) @(posedge clock);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/mwf_pkg.sv
hdl/mwf_front.sv
hdl/mwf_queue.sv
hdl/mwf_window.sv
hdl/mwf_median.sv
hdl/median_window_filter.sv
tb/median_window_filter_test.sv
